FILE: rtl/core/assert_macros.svh
// Assertion macros for the matrix inverse controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MI4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MI4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/mi4_pkg.sv
// Types, constants and address helpers for the 4x4 matrix inverse.
`default_nettype none

package mi4_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  // signed cofactor width
  localparam int CW  = 3 * DATA_WIDTH + 2;
  // accumulator / determinant width
  localparam int AW  = 4 * DATA_WIDTH + 3;
  // quotient bits kept below the overflow bit
  localparam int QB  = DATA_WIDTH + 1;
  // divider remainder and shifted divisor width
  localparam int DSW = 4 * DATA_WIDTH + 2 * FRAC_BITS + QB + 3;
  localparam int NCW = $clog2(QB + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COF,
    ST_COF_ST,
    ST_DET,
    ST_DET_FIN,
    ST_DIV_RD,
    ST_DIV_ABS,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_EMIT
  } fsm_e;

  typedef enum logic [1:0] {
    MUL_AB,
    MUL_LO,
    MUL_HI,
    MUL_LIMB
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [3:0] rd_addr;
    logic [3:0] cof_addr;
    logic       cof_we;
    mul_sel_e   mul_sel;
    logic [1:0] limb;
    logic       ld_opa;
    logic       ld_prod;
    acc_op_e    acc_op;
    logic [1:0] acc_shift;
    logic       det_ld;
    logic       div_abs;
    logic       div_init;
    logic       div_step;
    logic       out_ld;
    logic [3:0] out_index;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic out_hold;
  } sts_t;

  // i-th index of 0..3 with x left out
  function automatic logic [1:0] skip_idx(logic [1:0] x, logic [1:0] i);
    return (i < x) ? i : (i + 2'd1);
  endfunction

  // column pick of row i for permutation t of three
  function automatic logic [1:0] perm_col(logic [2:0] t, logic [1:0] i);
    logic [5:0] p;
    case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      3'd5:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    case (i)
      2'd0:    return p[1:0];
      2'd1:    return p[3:2];
      default: return p[5:4];
    endcase
  endfunction

  // storage address of factor i of term t for the cofactor at k = row*4 + col
  function automatic logic [3:0] cof_elem_addr(logic [3:0] k, logic [2:0] t, logic [1:0] i);
    logic [1:0] row;
    logic [1:0] col;
    row = skip_idx(k[3:2], i);
    col = skip_idx(k[1:0], perm_col(t, i));
    return {col, row};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mi4_datapath.sv
// Datapath: element store, shared multiplier, accumulator, divider, output register.
`default_nettype none

module mi4_datapath
  import mi4_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic signed [DATA_WIDTH-1:0] element_i,
  input  wire cmd_t                         cmd_i,
  output sts_t                              sts_o,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic signed [DATA_WIDTH-1:0]      result_element_o,
  output logic [3:0]                        result_index_o,
  output logic                              last_o,
  output logic                              singular_o
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0]          mem [16];
  logic [W-1:0]          rd_q;
  logic [CW-1:0]         cof_mem [16];
  logic [CW-1:0]         cof_rd_q;

  logic signed [W-1:0]   opa_q;
  logic signed [W-1:0]   prod_q;
  logic signed [W:0]     ma;
  logic signed [W:0]     mb;
  logic signed [2*W+1:0] mp_q;
  logic signed [2*W+1:0] mp_d;

  logic signed [AW-1:0]  acc_q;
  logic signed [AW-1:0]  acc_d;
  logic signed [AW-1:0]  add_ext;
  logic signed [AW-1:0]  add_sh;
  logic [4*W-1:0]        cof_ext;

  logic                  det_zero_q;
  logic                  det_neg_q;
  logic [AW-1:0]         dabs_q;
  logic [AW-1:0]         acc_u;
  logic [CW-1:0]         num_q;
  logic                  neg_q;
  logic [DSW-1:0]        rem_q;
  logic [DSW-1:0]        dsh_q;
  logic [QB:0]           q_q;
  logic                  ge;

  logic [QB:0]           lim;
  logic [QB:0]           mag;
  logic [QB:0]           sval;

  logic                  out_valid_q;
  logic [W-1:0]          out_elem_q;
  logic [3:0]            out_index_q;
  logic                  out_last_q;
  logic                  out_sing_q;

  // element store and cofactor store, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= element_i;
    end
    rd_q <= mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cof_we) begin
      cof_mem[cmd_i.cof_addr] <= acc_q[CW-1:0];
    end
    cof_rd_q <= cof_mem[cmd_i.cof_addr];
  end

  assign cof_ext = {{(4*W-CW){cof_rd_q[CW-1]}}, cof_rd_q};

  // shared multiplier operand select
  always_comb begin
    ma = {rd_q[W-1], rd_q};
    mb = {rd_q[W-1], rd_q};
    case (cmd_i.mul_sel)
      MUL_AB: ma = {opa_q[W-1], opa_q};
      MUL_LO: ma = {1'b0, mp_q[W-1:0]};
      MUL_HI: ma = {prod_q[W-1], prod_q};
      MUL_LIMB: begin
        case (cmd_i.limb)
          2'd0:    mb = {1'b0, cof_ext[W-1:0]};
          2'd1:    mb = {1'b0, cof_ext[2*W-1:W]};
          2'd2:    mb = {1'b0, cof_ext[3*W-1:2*W]};
          default: mb = {cof_ext[4*W-1], cof_ext[4*W-1:3*W]};
        endcase
      end
      default: ma = {opa_q[W-1], opa_q};
    endcase
    mp_d = ma * mb;
  end

  always_ff @(posedge clk_i) begin
    mp_q <= mp_d;
    if (cmd_i.ld_opa) begin
      opa_q <= rd_q;
    end
    // keep the upper half of the two-factor product
    if (cmd_i.ld_prod) begin
      prod_q <= mp_q[2*W-1:W];
    end
  end

  // accumulate the registered product at a limb offset
  always_comb begin
    add_ext = {{(AW-2*W-2){mp_q[2*W+1]}}, mp_q};
    case (cmd_i.acc_shift)
      2'd0:    add_sh = add_ext;
      2'd1:    add_sh = add_ext <<< W;
      2'd2:    add_sh = add_ext <<< (2 * W);
      default: add_sh = add_ext <<< (3 * W);
    endcase
    case (cmd_i.acc_op)
      ACC_CLR: acc_d = '0;
      ACC_ADD: acc_d = acc_q + add_sh;
      ACC_SUB: acc_d = acc_q - add_sh;
      default: acc_d = acc_q;
    endcase
  end

  assign acc_u = acc_q;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.det_ld) begin
      det_zero_q <= (acc_q == '0);
      det_neg_q  <= acc_q[AW-1];
      dabs_q     <= acc_q[AW-1] ? (AW'(0) - acc_u) : acc_u;
    end
  end

  // restoring divider, one quotient bit per cycle, top bit flags overflow
  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_abs) begin
      num_q <= cof_rd_q[CW-1] ? (CW'(0) - cof_rd_q) : cof_rd_q;
      neg_q <= cof_rd_q[CW-1] ^ det_neg_q;
    end
    if (cmd_i.div_init) begin
      rem_q <= (DSW'(num_q) << (2 * FRAC_BITS + 1)) + DSW'(dabs_q);
      dsh_q <= DSW'(dabs_q) << (QB + 1);
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[QB-1:0], ge};
    end
  end

  // saturate and apply sign
  always_comb begin
    lim  = neg_q ? ((QB+1)'(1) << (W - 1)) : (((QB+1)'(1) << (W - 1)) - (QB+1)'(1));
    mag  = (q_q > lim) ? lim : q_q;
    sval = neg_q ? ((QB+1)'(0) - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_elem_q  <= det_zero_q ? '0 : sval[W-1:0];
      out_index_q <= cmd_i.out_index;
      out_last_q  <= (cmd_i.out_index == 4'd15);
      out_sing_q  <= det_zero_q;
    end
  end

  assign sts_o.det_zero   = det_zero_q;
  assign sts_o.out_hold   = out_valid_q & out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign result_element_o = out_elem_q;
  assign result_index_o   = out_index_q;
  assign last_o           = out_last_q;
  assign singular_o       = out_sing_q;

endmodule

`default_nettype wire

FILE: rtl/core/mi4_ctrl.sv
// Controller: load, cofactor, determinant, divide and emit sequencing.
`default_nettype none

module mi4_ctrl
  import mi4_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

`include "assert_macros.svh"

  fsm_e           state_q, state_d;
  logic [3:0]     lc_q, lc_d;
  logic [3:0]     k_q, k_d;
  logic [2:0]     t_q, t_d;
  logic [2:0]     s_q, s_d;
  logic [NCW-1:0] n_q, n_d;
  logic           accept;
  logic           term_sub;

  assign in_stall_o = (state_q != ST_LOAD);
  assign accept     = in_valid_i & ~in_stall_o;
  assign term_sub   = (t_q >= 3'd3) ^ k_q[2] ^ k_q[0];

  always_comb begin
    state_d = state_q;
    lc_d    = lc_q;
    k_d     = k_q;
    t_d     = t_q;
    s_d     = s_q;
    n_d     = n_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          lc_d = lc_q + 4'd1;
          if (lc_q == 4'd15) begin
            state_d = ST_COF;
            k_d     = '0;
            t_d     = '0;
            s_d     = '0;
          end
        end
      end
      ST_COF: begin
        if (s_q == 3'd5) begin
          s_d = '0;
          if (t_q == 3'd5) begin
            t_d     = '0;
            state_d = ST_COF_ST;
          end else begin
            t_d = t_q + 3'd1;
          end
        end else begin
          s_d = s_q + 3'd1;
        end
      end
      ST_COF_ST: begin
        k_d = k_q + 4'd1;
        s_d = '0;
        state_d = (k_q == 4'd15) ? ST_DET : ST_COF;
      end
      ST_DET: begin
        if (s_q == 3'd5) begin
          s_d = '0;
          if (k_q == 4'd3) begin
            k_d     = '0;
            state_d = ST_DET_FIN;
          end else begin
            k_d = k_q + 4'd1;
          end
        end else begin
          s_d = s_q + 3'd1;
        end
      end
      ST_DET_FIN:  state_d = ST_DIV_RD;
      ST_DIV_RD:   state_d = sts_i.det_zero ? ST_EMIT : ST_DIV_ABS;
      ST_DIV_ABS:  state_d = ST_DIV_INIT;
      ST_DIV_INIT: begin
        n_d     = '0;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        n_d = n_q + NCW'(1);
        if (n_q == NCW'(QB)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_hold) begin
          k_d     = k_q + 4'd1;
          state_d = (k_q == 4'd15) ? ST_LOAD : ST_DIV_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_AB;
    cmd_o.acc_op    = ACC_HOLD;
    cmd_o.wr_addr   = lc_q;
    cmd_o.out_index = k_q;
    case (state_q)
      ST_LOAD: cmd_o.wr_en = accept;
      ST_COF: begin
        case (s_q)
          3'd0: begin
            cmd_o.rd_addr = cof_elem_addr(k_q, t_q, 2'd0);
            cmd_o.acc_op  = (t_q == 3'd0) ? ACC_CLR : ACC_HOLD;
          end
          3'd1: begin
            cmd_o.rd_addr = cof_elem_addr(k_q, t_q, 2'd1);
            cmd_o.ld_opa  = 1'b1;
          end
          3'd2: begin
            cmd_o.rd_addr = cof_elem_addr(k_q, t_q, 2'd2);
            cmd_o.mul_sel = MUL_AB;
          end
          3'd3: begin
            cmd_o.rd_addr = cof_elem_addr(k_q, t_q, 2'd2);
            cmd_o.mul_sel = MUL_LO;
            cmd_o.ld_prod = 1'b1;
          end
          3'd4: begin
            cmd_o.rd_addr   = cof_elem_addr(k_q, t_q, 2'd2);
            cmd_o.mul_sel   = MUL_HI;
            cmd_o.acc_op    = term_sub ? ACC_SUB : ACC_ADD;
            cmd_o.acc_shift = 2'd0;
          end
          default: begin
            cmd_o.acc_op    = term_sub ? ACC_SUB : ACC_ADD;
            cmd_o.acc_shift = 2'd1;
          end
        endcase
      end
      ST_COF_ST: begin
        cmd_o.cof_we   = 1'b1;
        cmd_o.cof_addr = k_q;
      end
      ST_DET: begin
        cmd_o.rd_addr  = {2'b00, k_q[1:0]};
        cmd_o.cof_addr = {k_q[1:0], 2'b00};
        cmd_o.mul_sel  = MUL_LIMB;
        case (s_q)
          3'd0: cmd_o.acc_op = (k_q == 4'd0) ? ACC_CLR : ACC_HOLD;
          3'd1: cmd_o.limb = 2'd0;
          3'd2: begin
            cmd_o.limb   = 2'd1;
            cmd_o.acc_op = ACC_ADD;
          end
          3'd3: begin
            cmd_o.limb      = 2'd2;
            cmd_o.acc_op    = ACC_ADD;
            cmd_o.acc_shift = 2'd1;
          end
          3'd4: begin
            cmd_o.limb      = 2'd3;
            cmd_o.acc_op    = ACC_ADD;
            cmd_o.acc_shift = 2'd2;
          end
          default: begin
            cmd_o.acc_op    = ACC_ADD;
            cmd_o.acc_shift = 2'd3;
          end
        endcase
      end
      ST_DET_FIN: cmd_o.det_ld = 1'b1;
      ST_DIV_RD:  cmd_o.cof_addr = k_q;
      ST_DIV_ABS: begin
        cmd_o.cof_addr = k_q;
        cmd_o.div_abs  = 1'b1;
      end
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV_STEP: cmd_o.div_step = 1'b1;
      ST_EMIT:     cmd_o.out_ld   = ~sts_i.out_hold;
      default:     cmd_o.wr_en    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      lc_q    <= '0;
      k_q     <= '0;
      t_q     <= '0;
      s_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      k_q     <= k_d;
      t_q     <= t_d;
      s_q     <= s_d;
      n_q     <= n_d;
    end
  end

  `MI4_ASSERT(a_load_done, (accept && lc_q == 4'd15) |=> (state_q == ST_COF), "no compute start")
  `MI4_ASSERT(a_no_emit_on_hold, cmd_o.out_ld |-> !sts_i.out_hold, "load over held result")
  `MI4_ASSERT(a_last_returns, (cmd_o.out_ld && k_q == 4'd15) |=> (state_q == ST_LOAD), "no reload")
  `MI4_ASSERT(a_count_idle, (lc_q == 4'd0) || (state_q == ST_LOAD), "count outside loading")

endmodule

`default_nettype wire

FILE: rtl/core/matrix4_inverse.sv
// Top level of the 4x4 fixed-point matrix inverse.
// Loading takes one request per cycle while in_stall_o is low; the sixteenth starts the compute.
// The sixteen cofactors are formed on one shared 33x33 multiplier, then the determinant,
// then each result passes the one-bit-per-cycle divider unless the matrix is singular.
// Reset clears control, not data storage.
`default_nettype none

module matrix4_inverse
  import mi4_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] element_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      result_element_o,
  output logic [3:0]                        result_index_o,
  output logic                              last_o,
  output logic                              singular_o
);

  cmd_t cmd;
  sts_t sts;

  mi4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mi4_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .element_i        (element_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .result_element_o (result_element_o),
    .result_index_o   (result_index_o),
    .last_o           (last_o),
    .singular_o       (singular_o)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import mi4_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct {
    elem_t      value;
    logic [3:0] index;
    logic       last;
    logic       singular;
  } inv_elem_t;

  // One directed matrix; known_inverse marks a diagonal result typed in here.
  typedef struct {
    elem_t cells[16];
    logic  known_inverse;
    elem_t diag_inverse;
    logic  known_singular;
  } matrix_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_DIRECTED = 4;
  localparam int N_RANDOM = 3;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  elem_t element_i;
  logic  out_valid_o;
  logic  out_stall_i;
  elem_t result_element_o;
  logic [3:0] result_index_o;
  logic  last_o;
  logic  singular_o;

  matrix4_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .element_i,
    .out_valid_o, .out_stall_i, .result_element_o, .result_index_o,
    .last_o, .singular_o
  );

  elem_t     loaded[16];
  int        load_slot;
  inv_elem_t pending_inverse[$];
  int        mismatches;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  matrix_row_t directed[N_DIRECTED];

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic wide_t entry(int row, int col);
    wide_t v;
    v = loaded[(col & 3) * 4 + (row & 3)];
    return v;
  endfunction

  // Signed 3x3 cofactor of the element at (row, col).
  function automatic wide_t cofactor(int row, int col);
    int rr[3];
    int cc[3];
    int n;
    int m;
    wide_t a[3][3];
    wide_t sum;
    n = 0;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != row) begin
        rr[n] = i;
        n++;
      end
      if (i != col) begin
        cc[m] = i;
        m++;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = entry(rr[i], cc[j]);
    sum = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
        - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
        + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    if (((row + col) & 1) != 0) sum = -sum;
    return sum;
  endfunction

  // Round to nearest, ties away from zero, then saturate.
  function automatic elem_t rounded_quotient(wide_t num, wide_t den);
    logic  neg;
    wide_t an;
    wide_t ad;
    wide_t q;
    wide_t lim;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    lim = neg ? (wide_t'(1) <<< (DATA_WIDTH - 1)) : (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[DATA_WIDTH-1:0];
  endfunction

  // Queue the sixteen inverse elements of the loaded matrix.
  task automatic predict_inverse();
    wide_t     det;
    inv_elem_t e;
    det = 0;
    for (int r = 0; r < 4; r++) det += entry(r, 0) * cofactor(r, 0);
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.last = (k == 15);
      e.singular = (det == 0);
      // adjugate: transposed cofactor
      e.value = e.singular ? '0
                           : rounded_quotient(cofactor(k / 4, k % 4) <<< (2 * FRAC_BITS), det);
      pending_inverse.push_back(e);
    end
  endtask

  task automatic push_typed(matrix_row_t m);
    inv_elem_t e;
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.last = (k == 15);
      e.singular = m.known_singular;
      e.value = (!m.known_singular && (k / 4 == k % 4)) ? m.diag_inverse : '0;
      pending_inverse.push_back(e);
    end
  endtask

  // Offer one request; returns after it was taken.
  task automatic send_element(elem_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    loaded[load_slot] = value;
    load_slot = (load_slot + 1) % 16;
    @(negedge clk_i);
  endtask

  task automatic send_matrix(matrix_row_t m);
    for (int i = 0; i < 16; i++) send_element(m.cells[i]);
    if (m.known_inverse || m.known_singular) push_typed(m);
    else predict_inverse();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_inverse.size() != 0) @(negedge clk_i);
  endtask

  function automatic elem_t random_element(int flavor);
    case (flavor)
      0:       return $urandom();
      1:       return $signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS);
      default: return $signed($urandom_range(255)) - 128;
    endcase
  endfunction

  always @(negedge clk_i)
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    inv_elem_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_inverse.size() == 0) begin
          report("unexpected result", result_index_o, -1);
        end else begin
          want = pending_inverse.pop_front();
          if (result_element_o !== want.value) report("element", result_element_o, want.value);
          if (result_index_o !== want.index) report("index", result_index_o, want.index);
          if (last_o !== want.last) report("last", last_o, want.last);
          if (singular_o !== want.singular) report("singular", singular_o, want.singular);
        end
      end
    end
  end

  initial begin
    matrix_row_t m;
    int          flavor;
    int          dup;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    element_i = '0;
    out_stall_i = 1'b0;
    load_slot = 0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 11;
    recv_stall_pct = 56;

    // identity, zero, tiny diagonal (saturates high), most negative diagonal
    foreach (directed[d]) begin
      directed[d].known_inverse = 1'b0;
      directed[d].known_singular = 1'b0;
      directed[d].diag_inverse = '0;
      for (int i = 0; i < 16; i++) directed[d].cells[i] = '0;
    end
    for (int i = 0; i < 16; i += 5) begin
      directed[0].cells[i] = elem_t'(1 << FRAC_BITS);
      directed[2].cells[i] = elem_t'(1);
      directed[3].cells[i] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end
    directed[0].known_inverse = 1'b1;
    directed[0].diag_inverse = elem_t'(1 << FRAC_BITS);
    directed[1].known_singular = 1'b1;
    directed[2].known_inverse = 1'b1;
    directed[2].diag_inverse = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[d]) send_matrix(directed[d]);
    // hold the sender until every result is back
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 1) begin
        send_idle_pct = 56;
        recv_stall_pct = 11;
      end else if (n == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      flavor = n % 3;
      m.known_inverse = 1'b0;
      m.known_singular = 1'b0;
      m.diag_inverse = '0;
      for (int i = 0; i < 16; i++) m.cells[i] = random_element(flavor);
      // copy one column onto another for a singular matrix
      if (n == 1) begin
        dup = $urandom_range(1, 3);
        for (int r = 0; r < 4; r++) m.cells[dup * 4 + r] = m.cells[r];
      end
      send_matrix(m);
    end
    in_valid_i <= 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
